FILE: rtl/core/bsu_pkg.sv
// Package for the bitmap set-union block: field widths, map geometry,
// queue sizing and the item and status structs shared by the other modules.
// Depends on nothing.
package bsu_pkg;

   localparam int CODE_BITS   = 16;
   localparam int CODE_W      = 16;
   localparam int INDEX_W     = 10;
   localparam int WORD_BITS   = 64;
   localparam int OFFSET_BITS = 6;
   localparam int ADDR_BITS   = CODE_BITS - OFFSET_BITS;
   localparam int WORD_COUNT  = 1 << ADDR_BITS;
   localparam int RAM_WIDTH   = 2 * WORD_BITS;

   localparam logic [WORD_BITS-1:0] TOP_BIT = {1'b1, {(WORD_BITS - 1){1'b0}}};

   localparam int Q_DEPTH    = 2;
   localparam int QPTR_BITS  = $clog2(Q_DEPTH);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SCAN   = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [ADDR_BITS-1:0]   addr;
      logic [OFFSET_BITS-1:0] offset;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

endpackage

FILE: rtl/core/bsu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

FILE: rtl/core/bsu_front.sv
// Front end: accepts items, reduces them to a map address and bit offset,
// and holds them in a short queue for the back end. Depends on bsu_pkg.
module bsu_front import bsu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [CODE_W-1:0]     req_code,
   input  logic [INDEX_W-1:0]    req_word_index,
   input  back_status_type       status,
   output queue_head_type        head
);

   item_type             entries_ff [Q_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic [31:0]          code_ext;
   logic [31:0]          index_ext;
   item_type             item;
   logic                 push;

   assign code_ext  = 32'(req_code);
   assign index_ext = 32'(req_word_index);

   always_comb begin
      item.op = req_operation;
      if (req_operation == OP_SCAN) begin
         item.addr   = index_ext[ADDR_BITS-1:0];
         item.offset = '0;
      end else begin
         item.addr   = code_ext[CODE_BITS-1:OFFSET_BITS];
         item.offset = code_ext[OFFSET_BITS-1:0];
      end
   end

   assign busy = status.clearing || (count_ff == (QPTR_BITS + 1)'(Q_DEPTH));
   assign push = start && !busy;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = status.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (QPTR_BITS + 1)'(push) - (QPTR_BITS + 1)'(status.pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/bsu_back.sv
// Back end: clears the map RAM after reset, then runs each queued item as a
// read-modify-write of the combined seen and duplicate word; a scan clears it.
// Depends on bsu_pkg and bsu_ram.
module bsu_back import bsu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  unique_only,
   input  queue_head_type        head,
   output back_status_type       status,
   output logic                  rsp_valid,
   output logic [INDEX_W-1:0]    rsp_scanned_word,
   output logic [WORD_BITS-1:0]  rsp_member_mask
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_FETCH,
      S_UPDATE
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_BITS-1:0]  clear_ff, clear_in;
   item_type              cur_ff, cur_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]    rsp_word_ff, rsp_word_in;
   logic [WORD_BITS-1:0]  rsp_mask_ff, rsp_mask_in;

   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [RAM_WIDTH-1:0]  ram_wdata;
   logic [RAM_WIDTH-1:0]  ram_rdata;
   logic [WORD_BITS-1:0]  seen;
   logic [WORD_BITS-1:0]  dup;
   logic [WORD_BITS-1:0]  bit_mask;

   bsu_ram #(
      .WIDTH(RAM_WIDTH),
      .DEPTH(WORD_COUNT)
   ) u_map_ram (
      .clock       (clock),
      .write_enable(ram_we),
      .write_addr  (ram_waddr),
      .write_data  (ram_wdata),
      .read_addr   (head.item.addr),
      .read_data   (ram_rdata)
   );

   assign seen     = ram_rdata[WORD_BITS-1:0];
   assign dup      = ram_rdata[RAM_WIDTH-1:WORD_BITS];
   assign bit_mask = TOP_BIT >> cur_ff.offset;

   always_comb begin
      state_in        = state_ff;
      clear_in        = clear_ff;
      cur_in          = cur_ff;
      rsp_valid_in    = 1'b0;
      rsp_word_in     = rsp_word_ff;
      rsp_mask_in     = rsp_mask_ff;
      ram_we          = 1'b0;
      ram_waddr       = cur_ff.addr;
      ram_wdata       = '0;
      status.clearing = 1'b0;
      status.pop      = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            status.clearing = 1'b1;
            ram_we          = 1'b1;
            ram_waddr       = clear_ff;
            clear_in        = clear_ff + 1'b1;
            if (clear_ff == ADDR_BITS'(WORD_COUNT - 1)) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (head.valid) begin
               status.pop = 1'b1;
               cur_in     = head.item;
               state_in   = S_UPDATE;
            end
         end
         S_UPDATE: begin
            ram_we   = 1'b1;
            state_in = S_FETCH;
            if (cur_ff.op == OP_SCAN) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = INDEX_W'(cur_ff.addr);
               rsp_mask_in  = unique_only ? (seen & ~dup) : seen;
            end else begin
               ram_wdata = {dup | (seen & bit_mask), seen | bit_mask};
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      rsp_word_ff <= rsp_word_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scanned_word = rsp_word_ff;
   assign rsp_member_mask  = rsp_mask_ff;

endmodule

FILE: rtl/core/bitmap_set_union_unique.sv
// Top level of the bitmap set-union block: mode register, front end, back end.
// Depends on bsu_pkg, bsu_front and bsu_back.
//
//   channel   ports                                         handshake
//   request   req_operation, req_code, req_word_index       start & !busy
//   response  rsp_scanned_word, rsp_member_mask             rsp_valid, one cycle
//   config    csr_write_data                                csr_write_enable
//
// Each item passes the back-end states S_FETCH, which reads the map word from
// the single read port, and S_UPDATE, which writes it back; a scan strobes its
// result the cycle after. After reset the 2^(CODE_BITS-6) = 1024 map words
// are cleared one word a cycle, busy high. A two-entry queue takes start while
// the back end works; busy rises when it is full. Results cannot be stalled.
module bitmap_set_union_unique import bsu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [CODE_W-1:0]     req_code,
   input  logic [INDEX_W-1:0]    req_word_index,
   output logic                  rsp_valid,
   output logic [INDEX_W-1:0]    rsp_scanned_word,
   output logic [WORD_BITS-1:0]  rsp_member_mask,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   logic            unique_only_ff, unique_only_in;
   queue_head_type  head;
   back_status_type status;

   assign unique_only_in = csr_write_enable ? csr_write_data : unique_only_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unique_only_ff <= 1'b0;
      end else begin
         unique_only_ff <= unique_only_in;
      end
   end

   bsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_code      (req_code),
      .req_word_index(req_word_index),
      .status        (status),
      .head          (head)
   );

   bsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .unique_only     (unique_only_ff),
      .head            (head),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_scanned_word(rsp_scanned_word),
      .rsp_member_mask (rsp_member_mask)
   );

`ifndef SYNTH
   a_no_back_to_back_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> head.valid)
      else $error("queue popped while empty");

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !rsp_valid && !status.pop)
      else $error("item handled during the clearing pass");
`endif

endmodule
